// ===== design/jpdm_pkg.sv =====
// Shared types and constants for the joystick packet drive mixer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package jpdm_pkg;

  localparam int AXIS_SLOTS_DEF   = 7;
  localparam int BUTTON_SLOTS_DEF = 8;

  // packet headers
  localparam logic [7:0] HDR_AXIS   = 8'h80;
  localparam logic [7:0] HDR_BUTTON = 8'h81;

  localparam logic PACKET_AXIS   = 1'b0;
  localparam logic PACKET_BUTTON = 1'b1;

  localparam logic [7:0] AXIS_RST_BASE = 8'd5;
  localparam logic [7:0] DUTY_IDLE     = 8'hFF;
  localparam logic [9:0] DUTY_MUL      = 10'd255;

  // configuration reset values
  localparam logic [7:0] DRIVE_SCALE_RST  = 8'd50;
  localparam logic [7:0] DEADZONE_RST     = 8'd10;
  localparam logic [9:0] GAIN_NORMAL_RST  = 10'd333;
  localparam logic [9:0] GAIN_BOOST_RST   = 10'd512;
  localparam logic [2:0] BOOST_BUTTON_RST = 3'd3;

  // shared multiplier shape
  localparam int MUL_A_W = 23;
  localparam int MUL_B_W = 10;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef enum logic [2:0] {
    CFG_DRIVE_SCALE,
    CFG_DEADZONE,
    CFG_GAIN_NORMAL,
    CFG_GAIN_BOOST,
    CFG_BOOST_BUTTON
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_AXIS_COUNT,
    PH_AXIS_DATA,
    PH_BTN_INDEX,
    PH_BTN_VALUE
  } parse_phase_t;

  typedef enum logic [3:0] {
    MX_IDLE,
    MX_SQUARE,
    MX_CUBE,
    MX_SHAPE,
    MX_SCALE,
    MX_TSTEP,
    MX_GAIN,
    MX_FINISH,
    MX_DONE
  } mix_state_t;

  typedef struct packed {
    logic       start;
    logic       kind;
  } mix_req_t;

  typedef struct packed {
    logic [7:0] left_in1;
    logic [7:0] left_in2;
    logic [7:0] right_in3;
    logic [7:0] right_in4;
    logic       kind;
  } mix_result_t;

  typedef struct packed {
    logic [7:0] drive_scale;
    logic [7:0] deadzone;
    logic [9:0] gain_normal;
    logic [9:0] gain_boost;
    logic [2:0] boost_button;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/jpdm_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on jpdm_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module jpdm_mul (
  input  logic                         clk,
  input  logic [jpdm_pkg::MUL_A_W-1:0] a,
  input  logic [jpdm_pkg::MUL_B_W-1:0] b,
  output logic [jpdm_pkg::MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= jpdm_pkg::MUL_P_W'(a) * jpdm_pkg::MUL_P_W'(b);
  end

endmodule

`default_nettype wire

// ===== design/jpdm_parse.sv =====
// Packet parser: header/count/index decoding plus the axis and button stores.
// Depends on jpdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jpdm_parse #(
  parameter int AXIS_SLOTS   = jpdm_pkg::AXIS_SLOTS_DEF,
  parameter int BUTTON_SLOTS = jpdm_pkg::BUTTON_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  input  logic [2:0]         boost_button,
  output logic [7:0]         axis0,
  output logic [7:0]         axis1,
  output logic               boost,
  output jpdm_pkg::mix_req_t req
);

  jpdm_pkg::parse_phase_t phase, phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] slot_index, slot_index_next;
  logic [7:0] bytes_dec;
  logic       axis_wr, button_wr;

  logic [7:0] axis_store   [AXIS_SLOTS];
  logic [7:0] button_store [BUTTON_SLOTS];

  assign bytes_dec = bytes_left - 8'd1;

  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    slot_index_next = slot_index;
    axis_wr         = 1'b0;
    button_wr       = 1'b0;
    req             = '0;
    if (accept) begin
      case (phase)
        jpdm_pkg::PH_IDLE: begin
          if (rx_byte == jpdm_pkg::HDR_AXIS) begin
            phase_next = jpdm_pkg::PH_AXIS_COUNT;
          end else if (rx_byte == jpdm_pkg::HDR_BUTTON) begin
            phase_next = jpdm_pkg::PH_BTN_INDEX;
          end
        end
        jpdm_pkg::PH_AXIS_COUNT: begin
          bytes_left_next = rx_byte;
          slot_index_next = '0;
          if (rx_byte == 8'd0) begin
            phase_next = jpdm_pkg::PH_IDLE;
            req.start  = 1'b1;
            req.kind   = jpdm_pkg::PACKET_AXIS;
          end else begin
            phase_next = jpdm_pkg::PH_AXIS_DATA;
          end
        end
        jpdm_pkg::PH_AXIS_DATA: begin
          axis_wr = 1'b1;
          if (slot_index != 8'hFF) begin
            slot_index_next = slot_index + 8'd1;
          end
          bytes_left_next = bytes_dec;
          if (bytes_dec == 8'd0) begin
            phase_next = jpdm_pkg::PH_IDLE;
            req.start  = 1'b1;
            req.kind   = jpdm_pkg::PACKET_AXIS;
          end
        end
        jpdm_pkg::PH_BTN_INDEX: begin
          slot_index_next = rx_byte;
          phase_next      = jpdm_pkg::PH_BTN_VALUE;
        end
        jpdm_pkg::PH_BTN_VALUE: begin
          button_wr  = 1'b1;
          phase_next = jpdm_pkg::PH_IDLE;
          req.start  = 1'b1;
          req.kind   = jpdm_pkg::PACKET_BUTTON;
        end
        default: begin
          phase_next = jpdm_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= jpdm_pkg::PH_IDLE;
      bytes_left <= '0;
      slot_index <= '0;
    end else begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      slot_index <= slot_index_next;
    end
  end

  // out-of-range slots simply match no entry
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXIS_SLOTS; i++) begin
        axis_store[i] <= jpdm_pkg::AXIS_RST_BASE + 8'(i);
      end
      for (int i = 0; i < BUTTON_SLOTS; i++) begin
        button_store[i] <= '0;
      end
    end else begin
      for (int i = 0; i < AXIS_SLOTS; i++) begin
        if (axis_wr && slot_index == 8'(i)) begin
          axis_store[i] <= rx_byte;
        end
      end
      for (int i = 0; i < BUTTON_SLOTS; i++) begin
        if (button_wr && slot_index == 8'(i)) begin
          button_store[i] <= rx_byte;
        end
      end
    end
  end

  assign axis0 = axis_store[0];
  assign axis1 = axis_store[1];

  always_comb begin
    boost = 1'b0;
    for (int i = 0; i < BUTTON_SLOTS; i++) begin
      if ({5'd0, boost_button} == 8'(i)) begin
        boost = (button_store[i] != 8'd0);
      end
    end
  end

  a_data_has_bytes: assert property (@(posedge clk) disable iff (rst)
    phase == jpdm_pkg::PH_AXIS_DATA |-> bytes_left != 8'd0)
    else $error("axis data phase with no bytes left");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |=> phase == jpdm_pkg::PH_IDLE)
    else $error("packet completed but parser not idle");

endmodule

`default_nettype wire

// ===== design/jpdm_mix.sv =====
// Mixing sequencer: cubes both axes, mixes, scales and gains each motor
// through one shared multiplier. Depends on jpdm_pkg and jpdm_mul.
`timescale 1ns / 1ps
`default_nettype none

module jpdm_mix (
  input  logic                  clk,
  input  logic                  rst,
  input  jpdm_pkg::mix_req_t    req,
  input  logic [7:0]            axis0,
  input  logic [7:0]            axis1,
  input  logic                  boost,
  input  jpdm_pkg::cfg_t        cfg,
  input  logic                  taken,
  output logic                  idle,
  output logic                  res_valid,
  output jpdm_pkg::mix_result_t res
);

  jpdm_pkg::mix_state_t state, state_next;

  logic                         ax;
  logic                         mot;
  logic signed [22:0]           c0, c1;
  logic [jpdm_pkg::MUL_A_W-1:0] mul_a;
  logic [jpdm_pkg::MUL_B_W-1:0] mul_b;
  logic [jpdm_pkg::MUL_P_W-1:0] prod;

  logic [7:0]         axis_cur, axis_mag;
  logic signed [22:0] cube_pos, shaped;
  logic signed [23:0] twice_c1, c0_ext, num, num_abs;
  logic               num_neg;
  logic [22:0]        num_mag;
  logic [9:0]         gain;
  logic [8:0]         m_val;
  logic [9:0]         t_val;
  logic [11:0]        d_raw;
  logic [7:0]         duty, drive;

  jpdm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign axis_cur = ax ? axis1 : axis0;
  assign axis_mag = axis_cur[7] ? (~axis_cur + 8'd1) : axis_cur;
  assign cube_pos = signed'({1'b0, prod[21:0]});
  assign shaped   = (axis_mag < cfg.deadzone) ? '0 : (axis_cur[7] ? -cube_pos : cube_pos);

  // Q22 mix: left = 2*c1 - c0, right = 2*c1 + c0
  assign twice_c1 = {c1, 1'b0};
  assign c0_ext   = {c0[22], c0};
  assign num      = mot ? (twice_c1 + c0_ext) : (twice_c1 - c0_ext);
  assign num_neg  = num[23];
  assign num_abs  = num_neg ? -num : num;
  assign num_mag  = num_abs[22:0];

  assign gain  = boost ? cfg.gain_boost : cfg.gain_normal;
  assign m_val = prod[30:22];
  assign t_val = prod[16:7];
  assign d_raw = prod[19:8];
  assign duty  = (d_raw > 12'd255) ? 8'hFF : d_raw[7:0];
  // zero magnitude gives duty 0, so both legs stay idle
  assign drive = jpdm_pkg::DUTY_IDLE - duty;

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      jpdm_pkg::MX_IDLE: begin
        if (req.start) begin
          state_next = jpdm_pkg::MX_SQUARE;
        end
      end
      jpdm_pkg::MX_SQUARE: begin
        mul_a      = jpdm_pkg::MUL_A_W'(axis_mag);
        mul_b      = jpdm_pkg::MUL_B_W'(axis_mag);
        state_next = jpdm_pkg::MX_CUBE;
      end
      jpdm_pkg::MX_CUBE: begin
        mul_a      = jpdm_pkg::MUL_A_W'(prod[14:0]);
        mul_b      = jpdm_pkg::MUL_B_W'(axis_mag);
        state_next = jpdm_pkg::MX_SHAPE;
      end
      jpdm_pkg::MX_SHAPE: begin
        state_next = ax ? jpdm_pkg::MX_SCALE : jpdm_pkg::MX_SQUARE;
      end
      jpdm_pkg::MX_SCALE: begin
        mul_a      = num_mag;
        mul_b      = jpdm_pkg::MUL_B_W'(cfg.drive_scale);
        state_next = jpdm_pkg::MX_TSTEP;
      end
      jpdm_pkg::MX_TSTEP: begin
        mul_a      = jpdm_pkg::MUL_A_W'(m_val);
        mul_b      = jpdm_pkg::DUTY_MUL;
        state_next = jpdm_pkg::MX_GAIN;
      end
      jpdm_pkg::MX_GAIN: begin
        mul_a      = jpdm_pkg::MUL_A_W'(t_val);
        mul_b      = gain;
        state_next = jpdm_pkg::MX_FINISH;
      end
      jpdm_pkg::MX_FINISH: begin
        state_next = mot ? jpdm_pkg::MX_DONE : jpdm_pkg::MX_SCALE;
      end
      jpdm_pkg::MX_DONE: begin
        if (taken) begin
          state_next = jpdm_pkg::MX_IDLE;
        end
      end
      default: begin
        state_next = jpdm_pkg::MX_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jpdm_pkg::MX_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      jpdm_pkg::MX_IDLE: begin
        ax       <= 1'b0;
        mot      <= 1'b0;
        res.kind <= req.kind;
      end
      jpdm_pkg::MX_SHAPE: begin
        if (ax) begin
          c1 <= shaped;
        end else begin
          c0 <= shaped;
        end
        ax <= 1'b1;
      end
      jpdm_pkg::MX_FINISH: begin
        if (mot) begin
          res.right_in3 <= num_neg ? jpdm_pkg::DUTY_IDLE : drive;
          res.right_in4 <= num_neg ? drive : jpdm_pkg::DUTY_IDLE;
        end else begin
          res.left_in1 <= num_neg ? jpdm_pkg::DUTY_IDLE : drive;
          res.left_in2 <= num_neg ? drive : jpdm_pkg::DUTY_IDLE;
        end
        mot <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign idle      = (state == jpdm_pkg::MX_IDLE);
  assign res_valid = (state == jpdm_pkg::MX_DONE);

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == jpdm_pkg::MX_IDLE)
    else $error("mix request while sequencer busy");

  a_second_motor_ends: assert property (@(posedge clk) disable iff (rst)
    state == jpdm_pkg::MX_FINISH && mot |=> state == jpdm_pkg::MX_DONE)
    else $error("sequence did not end after right motor");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    state == jpdm_pkg::MX_DONE && !taken |=> state == jpdm_pkg::MX_DONE && $stable(res))
    else $error("pending result changed before handoff");

endmodule

`default_nettype wire

// ===== design/joystick_packet_drive_mixer.sv =====
// Joystick packet drive mixer: byte-stream packet parser feeding an arcade
// mixer that drives two H-bridge duty pairs. Depends on jpdm_pkg, jpdm_parse,
// jpdm_mix and jpdm_mul.
//
// One received byte per request on the input channel. A byte that does not
// finish a packet leaves in_ready high. A byte that finishes an axis or
// button packet starts the mixer, which runs every multiply (two squares, two
// cubes, then drive scale, 255/128 duty step and gain for each motor) through
// one shared 23x10 multiplier: in_ready stays low while the mixer runs, plus
// any time the previous result still sits unclaimed in the output register.
// Each finished packet gives exactly one output request; unknown headers give
// none. Config writes are accepted every cycle and should only be made idle.
`timescale 1ns / 1ps
`default_nettype none

module joystick_packet_drive_mixer #(
  parameter int AXIS_SLOTS   = jpdm_pkg::AXIS_SLOTS_DEF,
  parameter int BUTTON_SLOTS = jpdm_pkg::BUTTON_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] left_in1_duty,
  output logic [7:0] left_in2_duty,
  output logic [7:0] right_in3_duty,
  output logic [7:0] right_in4_duty,
  output logic       packet_kind,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_data
);

  jpdm_pkg::cfg_t        cfg;
  jpdm_pkg::mix_req_t    req;
  jpdm_pkg::mix_result_t res;
  logic [7:0]            axis0, axis1;
  logic                  boost;
  logic                  mix_idle, res_valid, load, accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = mix_idle;
  assign accept    = in_valid && in_ready;
  assign load      = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_scale  <= jpdm_pkg::DRIVE_SCALE_RST;
      cfg.deadzone     <= jpdm_pkg::DEADZONE_RST;
      cfg.gain_normal  <= jpdm_pkg::GAIN_NORMAL_RST;
      cfg.gain_boost   <= jpdm_pkg::GAIN_BOOST_RST;
      cfg.boost_button <= jpdm_pkg::BOOST_BUTTON_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        jpdm_pkg::CFG_DRIVE_SCALE:  cfg.drive_scale  <= cfg_data[7:0];
        jpdm_pkg::CFG_DEADZONE:     cfg.deadzone     <= cfg_data[7:0];
        jpdm_pkg::CFG_GAIN_NORMAL:  cfg.gain_normal  <= cfg_data;
        jpdm_pkg::CFG_GAIN_BOOST:   cfg.gain_boost   <= cfg_data;
        jpdm_pkg::CFG_BOOST_BUTTON: cfg.boost_button <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  jpdm_parse #(
    .AXIS_SLOTS   (AXIS_SLOTS),
    .BUTTON_SLOTS (BUTTON_SLOTS)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .rx_byte      (rx_byte),
    .boost_button (cfg.boost_button),
    .axis0        (axis0),
    .axis1        (axis1),
    .boost        (boost),
    .req          (req)
  );

  jpdm_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .axis0     (axis0),
    .axis1     (axis1),
    .boost     (boost),
    .cfg       (cfg),
    .taken     (load),
    .idle      (mix_idle),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register decouples the mixer from the downstream stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_in1_duty  <= res.left_in1;
      left_in2_duty  <= res.left_in2;
      right_in3_duty <= res.right_in3;
      right_in4_duty <= res.right_in4;
      packet_kind    <= res.kind;
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_joystick_packet_drive_mixer.sv =====
// Testbench for joystick_packet_drive_mixer: feeds link bytes and checks every duty result
// against a local packet parser and arcade mixer. Depends on jpdm_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_joystick_packet_drive_mixer;

  localparam int AXIS_N        = jpdm_pkg::AXIS_SLOTS_DEF;
  localparam int BUTTON_N      = jpdm_pkg::BUTTON_SLOTS_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_LIMIT    = 3000;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] left_in1_duty;
  logic [7:0] left_in2_duty;
  logic [7:0] right_in3_duty;
  logic [7:0] right_in4_duty;
  logic       packet_kind;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = 3'd0;
  logic [9:0] cfg_data  = 10'd0;

  joystick_packet_drive_mixer dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .left_in1_duty (left_in1_duty),
    .left_in2_duty (left_in2_duty),
    .right_in3_duty(right_in3_duty),
    .right_in4_duty(right_in4_duty),
    .packet_kind   (packet_kind),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // mirrored configuration and parser state
  logic [7:0]             scale_r;
  logic [7:0]             dz_r;
  logic [9:0]             gain_n_r;
  logic [9:0]             gain_b_r;
  logic [2:0]             boost_r;
  jpdm_pkg::parse_phase_t phase_m;
  logic [7:0]             left_m;
  logic [7:0]             slot_m;
  logic [7:0]             axis_m   [AXIS_N];
  logic [7:0]             button_m [BUTTON_N];

  logic [7:0]            byte_queue [$];
  jpdm_pkg::mix_result_t duty_expect_q [$];
  int                    fail_count = 0;
  bit                    no_gaps    = 1'b0;

  task automatic note_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic int draw_gap();
    return no_gaps ? 0 : int'($urandom_range(0, 8));
  endfunction

  function automatic void reset_mirror();
    scale_r  = jpdm_pkg::DRIVE_SCALE_RST;
    dz_r     = jpdm_pkg::DEADZONE_RST;
    gain_n_r = jpdm_pkg::GAIN_NORMAL_RST;
    gain_b_r = jpdm_pkg::GAIN_BOOST_RST;
    boost_r  = jpdm_pkg::BOOST_BUTTON_RST;
    phase_m  = jpdm_pkg::PH_IDLE;
    left_m   = 8'd0;
    slot_m   = 8'd0;
    for (int i = 0; i < AXIS_N; i++) axis_m[i] = jpdm_pkg::AXIS_RST_BASE + 8'(i);
    for (int i = 0; i < BUTTON_N; i++) button_m[i] = 8'd0;
  endfunction

  // deadzone then cube; a^3 is a/128 cubed in Q21
  function automatic longint shape_axis(int slot);
    longint a;
    longint mag;
    a = $signed(axis_m[slot]);
    mag = (a < 0) ? -a : a;
    if (mag < longint'(dz_r)) return 0;
    return a * a * a;
  endfunction

  function automatic void drive_pair(longint mix_val, logic [9:0] gain,
                                     output logic [7:0] fwd, output logic [7:0] rev);
    longint unsigned mag;
    longint unsigned m;
    longint unsigned t;
    longint unsigned d;
    mag = (mix_val < 0) ? -mix_val : mix_val;
    m = (mag * scale_r) >> 22;
    t = (m * 255) / 128;
    d = (t * gain) >> 8;
    if (d > 255) d = 255;
    fwd = jpdm_pkg::DUTY_IDLE;
    rev = jpdm_pkg::DUTY_IDLE;
    if (m != 0) begin
      if (mix_val > 0) fwd = 8'(255 - d);
      else rev = 8'(255 - d);
    end
  endfunction

  function automatic jpdm_pkg::mix_result_t mix_duties(logic kind);
    jpdm_pkg::mix_result_t r;
    longint c0;
    longint c1;
    logic [9:0] g;
    c0 = shape_axis(0);
    c1 = shape_axis(1);
    g = gain_n_r;
    // boost_r is 3 bits, so it always lands inside the eight button slots
    if (button_m[boost_r] != 8'd0) g = gain_b_r;
    drive_pair(2 * c1 - c0, g, r.left_in1, r.left_in2);
    drive_pair(2 * c1 + c0, g, r.right_in3, r.right_in4);
    r.kind = kind;
    return r;
  endfunction

  function automatic void advance_parser(logic [7:0] b, output bit done,
                                         output jpdm_pkg::mix_result_t res);
    done = 1'b0;
    res = '0;
    case (phase_m)
      jpdm_pkg::PH_AXIS_COUNT: begin
        left_m = b;
        slot_m = 8'd0;
        if (b == 8'd0) begin
          phase_m = jpdm_pkg::PH_IDLE;
          done = 1'b1;
          res = mix_duties(jpdm_pkg::PACKET_AXIS);
        end else begin
          phase_m = jpdm_pkg::PH_AXIS_DATA;
        end
      end
      jpdm_pkg::PH_AXIS_DATA: begin
        if (slot_m < AXIS_N) axis_m[slot_m] = b;
        if (slot_m != 8'hFF) slot_m = slot_m + 8'd1;
        left_m = left_m - 8'd1;
        if (left_m == 8'd0) begin
          phase_m = jpdm_pkg::PH_IDLE;
          done = 1'b1;
          res = mix_duties(jpdm_pkg::PACKET_AXIS);
        end
      end
      jpdm_pkg::PH_BTN_INDEX: begin
        slot_m = b;
        phase_m = jpdm_pkg::PH_BTN_VALUE;
      end
      jpdm_pkg::PH_BTN_VALUE: begin
        if (slot_m < BUTTON_N) button_m[slot_m] = b;
        phase_m = jpdm_pkg::PH_IDLE;
        done = 1'b1;
        res = mix_duties(jpdm_pkg::PACKET_BUTTON);
      end
      default: begin
        if (b == jpdm_pkg::HDR_AXIS) phase_m = jpdm_pkg::PH_AXIS_COUNT;
        else if (b == jpdm_pkg::HDR_BUTTON) phase_m = jpdm_pkg::PH_BTN_INDEX;
        else phase_m = jpdm_pkg::PH_IDLE;
      end
    endcase
  endfunction

  // byte driver: gap drawn per request, applied after it is taken
  always @(posedge clk) begin : drive_bytes
    int gap_left;
    bit done;
    jpdm_pkg::mix_result_t res;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        advance_parser(rx_byte, done, res);
        if (done) duty_expect_q.push_back(res);
      end
      if ((in_valid && in_ready) || !in_valid) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          rx_byte <= byte_queue.pop_front();
          in_valid <= 1'b1;
          gap_left = draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random backpressure
  always @(posedge clk) begin : watch_duties
    int stall_left;
    int n;
    jpdm_pkg::mix_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (out_valid && out_ready) begin
      if (duty_expect_q.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: %0d %0d %0d %0d kind %0d",
                                left_in1_duty, left_in2_duty, right_in3_duty,
                                right_in4_duty, packet_kind));
      end else begin
        want = duty_expect_q.pop_front();
        check_field("left_in1_duty", left_in1_duty, want.left_in1);
        check_field("left_in2_duty", left_in2_duty, want.left_in2);
        check_field("right_in3_duty", right_in3_duty, want.right_in3);
        check_field("right_in4_duty", right_in4_duty, want.right_in4);
        check_field("packet_kind", 8'(packet_kind), 8'(want.kind));
      end
      n = draw_gap();
      stall_left = n;
      out_ready <= (n == 0);
    end else if (!out_ready) begin
      if (stall_left == 0) out_ready <= 1'b1;
      else stall_left = stall_left - 1;
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no request taken for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(jpdm_pkg::cfg_index_t idx, logic [9:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      jpdm_pkg::CFG_DRIVE_SCALE:  scale_r  = val[7:0];
      jpdm_pkg::CFG_DEADZONE:     dz_r     = val[7:0];
      jpdm_pkg::CFG_GAIN_NORMAL:  gain_n_r = val;
      jpdm_pkg::CFG_GAIN_BOOST:   gain_b_r = val;
      jpdm_pkg::CFG_BOOST_BUTTON: boost_r  = val[2:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int scale, int dz, int gn, int gb, int bb);
    write_reg(jpdm_pkg::CFG_DRIVE_SCALE, 10'(scale));
    write_reg(jpdm_pkg::CFG_DEADZONE, 10'(dz));
    write_reg(jpdm_pkg::CFG_GAIN_NORMAL, 10'(gn));
    write_reg(jpdm_pkg::CFG_GAIN_BOOST, 10'(gb));
    write_reg(jpdm_pkg::CFG_BOOST_BUTTON, 10'(bb));
  endtask

  // sampled at negedge so the driver's update of the queue has settled
  task automatic drain_all();
    do @(negedge clk); while (byte_queue.size() != 0 || in_valid || duty_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_axis_byte();
    case ($urandom_range(0, 9))
      0: return 8'h7F;
      1: return 8'h80;
      2: return 8'h81;
      3: return dz_r;
      4: return 8'(-dz_r);
      5: return dz_r - 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int pick_axis_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 10) return 1;
    if (r < 75) return 2;
    if (r < 90) return $urandom_range(3, 7);
    return $urandom_range(8, 12);
  endfunction

  // mostly whole packets; loose bytes can open a packet that the next one breaks
  task automatic queue_random_stream(int target);
    int sent;
    int r;
    int cnt;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        cnt = pick_axis_count();
        byte_queue.push_back(jpdm_pkg::HDR_AXIS);
        byte_queue.push_back(8'(cnt));
        for (int i = 0; i < cnt; i++) byte_queue.push_back(pick_axis_byte());
        sent += cnt + 2;
      end else if (r < 85) begin
        byte_queue.push_back(jpdm_pkg::HDR_BUTTON);
        if ($urandom_range(0, 4) == 0) byte_queue.push_back(8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 1) == 0) byte_queue.push_back(8'(boost_r));
        else byte_queue.push_back(8'($urandom_range(0, BUTTON_N - 1)));
        if ($urandom_range(0, 1) == 0) byte_queue.push_back(8'd0);
        else byte_queue.push_back(8'($urandom_range(1, 255)));
        sent += 3;
      end else begin
        byte_queue.push_back(8'($urandom_range(0, 255)));
        sent += 1;
      end
    end
  endtask

  // two halves with a full hold-off between them
  task automatic run_phase(int scale, int dz, int gn, int gb, int bb, int items);
    set_config(scale, dz, gn, gb, bb);
    queue_random_stream(items / 2);
    drain_all();
    queue_random_stream(items - items / 2);
    drain_all();
  endtask

  initial begin
    reset_mirror();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    byte_queue = {8'h00, 8'hFF,                              // unknown headers are dropped
                  jpdm_pkg::HDR_AXIS, 8'h00,                 // empty axis packet
                  jpdm_pkg::HDR_AXIS, 8'h02, 8'h7F, 8'h7F,
                  jpdm_pkg::HDR_AXIS, 8'h02, 8'h80, 8'h80,
                  jpdm_pkg::HDR_BUTTON, 8'h03, 8'h01,        // boost on
                  jpdm_pkg::HDR_BUTTON, 8'hC8, 8'h05,        // index past last slot
                  jpdm_pkg::HDR_AXIS, 8'h08, 8'h0A, 8'hF7, 8'h81, 8'h00, 8'hFF, 8'h7F,
                  8'h01,
                  8'h80};                                    // eighth axis byte is discarded
    drain_all();

    run_phase(255, 0, 1023, 1023, 7, 110);
    run_phase(0, 128, 0, 0, 0, 100);
    run_phase(1, 0, 256, 1023, 3, 100);
    // longest axis packet
    byte_queue.push_back(jpdm_pkg::HDR_AXIS);
    byte_queue.push_back(8'hFF);
    for (int i = 0; i < 255; i++) byte_queue.push_back(pick_axis_byte());
    drain_all();

    for (int p = 0; p < 4; p++) begin
      no_gaps = (p == 1);
      run_phase($urandom_range(0, 255),
                ($urandom_range(0, 4) == 0) ? $urandom_range(129, 255) : $urandom_range(0, 40),
                $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 7), 70);
    end

    if (duty_expect_q.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", duty_expect_q.size()));
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
